// ----- sv/bwpu_pkg.sv -----
// ============================================================================
// bwpu_pkg - shared types and constants for the wheel pose update block
// Angle formats, CORDIC table, arithmetic helpers and unit handshake structs.
// ============================================================================
`default_nettype none
package bwpu_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int CW               = 34;   // CORDIC datapath width, Q30 plus headroom

    localparam logic signed [16:0] PI_Q      = 17'sd12868;
    localparam logic signed [16:0] TWO_PI_Q  = 17'sd25736;
    localparam logic signed [16:0] HALF_PI_Q = 17'sd6434;
    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

    localparam logic [19:0] REAR_ARM_RST  = 20'd63570;
    localparam logic [19:0] FRONT_ARM_RST = 20'd65536;

    localparam logic CFG_REAR_ARM  = 1'b0;
    localparam logic CFG_FRONT_ARM = 1'b1;

    typedef struct packed {
        logic                 start;
        logic signed [14:0]   angle;
    } cordic_req_t;

    typedef struct packed {
        logic                 done;
        logic signed [CW-1:0] cos_q30;
        logic signed [CW-1:0] sin_q30;
    } cordic_rsp_t;

    typedef struct packed {
        logic        start;
        logic [26:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [26:0] quotient;
    } div_rsp_t;

    function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [CW-1:0] v;
        case (idx)
            5'd0:    v = 34'sh03243F6A8;
            5'd1:    v = 34'sh01DAC6705;
            5'd2:    v = 34'sh00FADBAFC;
            5'd3:    v = 34'sh007F56EA6;
            5'd4:    v = 34'sh003FEAB76;
            5'd5:    v = 34'sh001FFD55B;
            5'd6:    v = 34'sh000FFFAAA;
            5'd7:    v = 34'sh0007FFF55;
            5'd8:    v = 34'sh0003FFFEA;
            5'd9:    v = 34'sh0001FFFFD;
            5'd10:   v = 34'sh0000FFFFF;
            5'd11:   v = 34'sh00007FFFF;
            5'd12:   v = 34'sh00003FFFF;
            5'd13:   v = 34'sh00001FFFF;
            5'd14:   v = 34'sh00000FFFF;
            5'd15:   v = 34'sh000007FFF;
            5'd16:   v = 34'sh000003FFF;
            5'd17:   v = 34'sh000001FFF;
            5'd18:   v = 34'sh000000FFF;
            5'd19:   v = 34'sh0000007FF;
            5'd20:   v = 34'sh0000003FF;
            5'd21:   v = 34'sh0000001FF;
            5'd22:   v = 34'sh0000000FF;
            5'd23:   v = 34'sh00000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

    // one correction step covers every input range used here
    function automatic logic signed [16:0] wrap_pi(input logic signed [16:0] a);
        logic signed [16:0] r;
        if (a > PI_Q)
            r = a - TWO_PI_Q;
        else if (a < -PI_Q)
            r = a + TWO_PI_Q;
        else
            r = a;
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh07FFFFFFF)
            r = 32'sh7FFFFFFF;
        else if (v < -34'sh080000000)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- sv/bwpu_if.sv -----
// ============================================================================
// bwpu_in_if / bwpu_out_if - valid/ready channels of the pose update block
// Sample words in, pose words out.
// ============================================================================
`default_nettype none
interface bwpu_in_if;
    logic               valid;
    logic               ready;
    logic        [15:0] time_step;
    logic signed [15:0] speed_in;
    logic signed [15:0] steer_angle_in;
    logic signed [15:0] body_yaw_in;
    logic signed [31:0] sensor_x;
    logic signed [31:0] sensor_y;

    modport source (output valid, time_step, speed_in, steer_angle_in, body_yaw_in,
                    sensor_x, sensor_y, input ready);
    modport sink   (input valid, time_step, speed_in, steer_angle_in, body_yaw_in,
                    sensor_x, sensor_y, output ready);
endinterface

interface bwpu_out_if;
    logic               valid;
    logic               ready;
    logic        [14:0] speed_out;
    logic signed [14:0] body_yaw_out;
    logic signed [14:0] steer_angle_out;
    logic signed [26:0] steer_rate;
    logic signed [31:0] rear_x;
    logic signed [31:0] rear_y;
    logic signed [14:0] front_heading;
    logic signed [31:0] front_x;
    logic signed [31:0] front_y;
    logic               zero_step_flag;

    modport source (output valid, speed_out, body_yaw_out, steer_angle_out, steer_rate,
                    rear_x, rear_y, front_heading, front_x, front_y, zero_step_flag,
                    input ready);
    modport sink   (input valid, speed_out, body_yaw_out, steer_angle_out, steer_rate,
                    rear_x, rear_y, front_heading, front_x, front_y, zero_step_flag,
                    output ready);
endinterface
`default_nettype wire

// ----- sv/bwpu_cordic.sv -----
// ============================================================================
// bwpu_cordic - iterative rotation-mode CORDIC
// One micro-rotation per cycle; quadrant fold and result negation around it.
// ============================================================================
`default_nettype none
module bwpu_cordic
    import bwpu_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cordic_req_t req,
    output cordic_rsp_t rsp
);
    localparam int STEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic signed [CW-1:0] x_next, y_next, z_next;
    logic [4:0]           i_reg, i_next;
    logic                 busy_reg, busy_next, done_reg, done_next, flip_reg, flip_next;
    logic signed [16:0]   a_ext, a_red;
    logic signed [CW-1:0] xs, ys;

    always_comb
    begin
        a_ext = 17'(req.angle);
        a_red = a_ext;
        flip_next = flip_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        i_next = i_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        if (a_ext > HALF_PI_Q)
            a_red = a_ext - PI_Q;
        else if (a_ext < -HALF_PI_Q)
            a_red = a_ext + PI_Q;
        if (req.start)
        begin
            flip_next = (a_ext > HALF_PI_Q) || (a_ext < -HALF_PI_Q);
            x_next    = GAIN_Q30;
            y_next    = '0;
            z_next    = CW'(a_red) <<< 18;
            i_next    = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            // rotate toward zero residual angle
            if (!z_reg[CW-1])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_q30(i_reg);
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_q30(i_reg);
            end
            i_next = i_reg + 5'd1;
            if (i_reg == 5'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            i_reg    <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.cos_q30 = flip_reg ? -x_reg : x_reg;
    assign rsp.sin_q30 = flip_reg ? -y_reg : y_reg;

endmodule
`default_nettype wire

// ----- sv/bwpu_div.sv -----
// ============================================================================
// bwpu_div - restoring unsigned divider
// One quotient bit per cycle for a 27-bit quotient.
// ============================================================================
`default_nettype none
module bwpu_div
    import bwpu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire div_req_t req,
    output div_rsp_t  rsp
);
    logic [26:0] q_reg, q_next;
    logic [15:0] rem_reg, rem_next, d_reg, d_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next, done_reg, done_next;
    logic [16:0] trial;

    always_comb
    begin
        q_next = q_reg;
        rem_next = rem_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        trial = {rem_reg, q_reg[26]};
        if (req.start)
        begin
            q_next    = req.dividend;
            rem_next  = '0;
            d_next    = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            // shift in next dividend bit, subtract when it fits
            if (trial >= {1'b0, d_reg})
            begin
                rem_next = 16'(trial - {1'b0, d_reg});
                q_next   = {q_reg[25:0], 1'b1};
            end
            else
            begin
                rem_next = trial[15:0];
                q_next   = {q_reg[25:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd26)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule
`default_nettype wire

// ----- sv/bicycle_wheel_pose_update.sv -----
// ============================================================================
// bicycle_wheel_pose_update - rear and front wheel pose from odometry samples
// Wraps angles, derives steering rate, places wheel centres via CORDIC.
// ============================================================================
//
//  channel  | dir | handshake        | word
//  ---------+-----+------------------+-----------------------------------------
//  in_ch    | in  | valid/ready      | time_step, speed, steer, yaw, sensor x/y
//  out_ch   | out | valid/ready      | speed, angles, rate, rear/front x/y, flag
//  cfg      | in  | cfg_we           | cfg_index selects arm length, cfg_data
//
//  An input word makes two back-to-back passes through the one CORDIC unit,
//  each followed by multiply-accumulate steps; the divider runs beside.
//  in_ch.ready is high only in the idle state. A finished pose is held in the
//  output register, so the next word is taken while out_ch stalls; a second
//  pose waits in the final state until the output register frees.
//  Reset clears the previous steering angle and loads the default arm lengths.
// ============================================================================
`default_nettype none
module bicycle_wheel_pose_update
    import bwpu_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    bwpu_in_if.sink          in_ch,
    bwpu_out_if.source       out_ch,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [19:0] cfg_data
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_COR1  = 7'b0000010,
        ST_MUL1  = 7'b0000100,
        ST_REAR  = 7'b0001000,
        ST_COR2  = 7'b0010000,
        ST_MUL2  = 7'b0100000,
        ST_FRONT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [19:0]        rear_arm_reg, front_arm_reg;
    logic signed [14:0] prev_steer_reg;
    logic signed [14:0] steer_reg, yaw_reg, fh_reg;
    logic [14:0]        speed_reg;
    logic signed [31:0] sx_reg, sy_reg, rx_reg, ry_reg;
    logic               flag_reg, neg_reg;
    logic signed [55:0] acc_x_reg, acc_y_reg;
    logic [1:0]         mcnt_reg;

    logic               out_valid_reg;
    logic               in_acc, out_free, front_go;

    logic signed [16:0] steer_w, yaw_w, diff_w, fh_w;
    logic [13:0]        diff_mag;

    cordic_req_t        cor_req;
    cordic_rsp_t        cor_rsp;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic signed [CW-1:0] mul_t;
    logic signed [17:0]   mul_b;
    logic signed [38:0]   mul_p;
    logic signed [55:0]   mul_term;
    logic [19:0]          mul_arm;

    logic signed [55:0] rnd_x, rnd_y;
    logic signed [31:0] rx_w, ry_w, fx_w, fy_w;
    logic signed [26:0] rate_w;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign front_go    = (state_reg == ST_FRONT) && out_free && (flag_reg || div_rsp.done);

    // angle front end: wrap inputs, the steering difference and the front heading
    always_comb
    begin
        steer_w  = wrap_pi(17'(in_ch.steer_angle_in));
        yaw_w    = wrap_pi(17'(in_ch.body_yaw_in));
        diff_w   = wrap_pi(steer_w - 17'(prev_steer_reg));
        diff_mag = diff_w[16] ? 14'(-diff_w) : 14'(diff_w);
        fh_w     = wrap_pi(17'(yaw_reg) + 17'(steer_reg));
    end

    always_comb
    begin
        div_req.start    = in_acc && (in_ch.time_step != 16'd0);
        div_req.dividend = {1'b0, diff_mag, 12'd0};
        div_req.divisor  = in_ch.time_step;
        cor_req.start    = in_acc || (state_reg == ST_REAR);
        cor_req.angle    = (state_reg == ST_IDLE) ? 15'(yaw_w) : 15'(fh_w);
    end

    bwpu_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cor_req),
        .rsp   (cor_rsp)
    );

    bwpu_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // shared multiplier: arm times one 17-bit slice of cos or sin per cycle
    always_comb
    begin
        mul_arm  = (state_reg == ST_MUL2) ? front_arm_reg : rear_arm_reg;
        mul_t    = mcnt_reg[1] ? cor_rsp.sin_q30 : cor_rsp.cos_q30;
        mul_b    = mcnt_reg[0] ? 18'($signed(mul_t[CW-1:17])) : $signed({1'b0, mul_t[16:0]});
        mul_p    = $signed({1'b0, mul_arm}) * mul_b;
        mul_term = mcnt_reg[0] ? (56'(mul_p) <<< 17) : 56'(mul_p);
    end

    // round to Q16.16 and combine with the positions
    always_comb
    begin
        rnd_x  = acc_x_reg + (56'sd1 <<< 29);
        rnd_y  = acc_y_reg + (56'sd1 <<< 29);
        rx_w   = sat32(34'(sx_reg) - 34'($signed(rnd_x[55:30])));
        ry_w   = sat32(34'(sy_reg) - 34'($signed(rnd_y[55:30])));
        fx_w   = sat32(34'(rx_reg) + 34'($signed(rnd_x[55:30])));
        fy_w   = sat32(34'(ry_reg) + 34'($signed(rnd_y[55:30])));
        rate_w = flag_reg ? 27'sd0 :
                 (neg_reg ? -$signed(div_rsp.quotient) : $signed(div_rsp.quotient));
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_acc) state_next = ST_COR1;
            ST_COR1:  if (cor_rsp.done) state_next = ST_MUL1;
            ST_MUL1:  if (mcnt_reg == 2'd3) state_next = ST_REAR;
            ST_REAR:  state_next = ST_COR2;
            ST_COR2:  if (cor_rsp.done) state_next = ST_MUL2;
            ST_MUL2:  if (mcnt_reg == 2'd3) state_next = ST_FRONT;
            ST_FRONT: if (front_go) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            prev_steer_reg <= '0;
            rear_arm_reg   <= REAR_ARM_RST;
            front_arm_reg  <= FRONT_ARM_RST;
            mcnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_REAR_ARM:  rear_arm_reg  <= cfg_data;
                    CFG_FRONT_ARM: front_arm_reg <= cfg_data;
                    default:       rear_arm_reg  <= rear_arm_reg;
                endcase
            end
            if (in_acc)
                prev_steer_reg <= 15'(steer_w);
            if ((state_reg == ST_MUL1) || (state_reg == ST_MUL2))
                mcnt_reg <= mcnt_reg + 2'd1;
            else
                mcnt_reg <= '0;
            // hold the pose until taken
            if (front_go)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            steer_reg <= 15'(steer_w);
            yaw_reg   <= 15'(yaw_w);
            speed_reg <= in_ch.speed_in[15] ? 15'd0 : in_ch.speed_in[14:0];
            sx_reg    <= in_ch.sensor_x;
            sy_reg    <= in_ch.sensor_y;
            flag_reg  <= (in_ch.time_step == 16'd0);
            neg_reg   <= diff_w[16];
        end
        if ((state_reg == ST_MUL1) || (state_reg == ST_MUL2))
        begin
            if (mcnt_reg[1])
                acc_y_reg <= acc_y_reg + mul_term;
            else
                acc_x_reg <= acc_x_reg + mul_term;
        end
        else if (state_reg != ST_FRONT)
        begin
            // keep the front products while the pose waits for the output register
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end
        if (state_reg == ST_REAR)
        begin
            rx_reg <= rx_w;
            ry_reg <= ry_w;
            fh_reg <= 15'(fh_w);
        end
        if (front_go)
        begin
            out_ch.speed_out       <= speed_reg;
            out_ch.body_yaw_out    <= yaw_reg;
            out_ch.steer_angle_out <= steer_reg;
            out_ch.steer_rate      <= rate_w;
            out_ch.rear_x          <= rx_reg;
            out_ch.rear_y          <= ry_reg;
            out_ch.front_heading   <= fh_reg;
            out_ch.front_x         <= fx_w;
            out_ch.front_y         <= fy_w;
            out_ch.zero_step_flag  <= flag_reg;
        end
    end

    assign out_ch.valid = out_valid_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ch.ready)
        else $error("block still ready after taking a word");

    a_zero_step_rate: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.zero_step_flag |-> out_ch.steer_rate == 27'sd0)
        else $error("nonzero rate with zero time step");

    a_yaw_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (17'(out_ch.body_yaw_out) <= PI_Q) &&
                         (17'(out_ch.body_yaw_out) >= -PI_Q))
        else $error("body yaw outside wrap range");

    a_div_done_at_release: assert property (@(posedge clk) disable iff (!rst_n)
        front_go |-> flag_reg || div_rsp.done)
        else $error("pose released before rate was ready");

endmodule
`default_nettype wire
